// ===== rtl/core/double_ended_queue_unit_defines.svh =====
// assertion macros for the deque unit
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deque assertion failed");
`define DEQ_ASSERT(lbl, prop) `DEQ_ASSERT_CLK(lbl, clock, reset, prop)
`else
`define DEQ_ASSERT_CLK(lbl, clk, rst, prop)
`define DEQ_ASSERT(lbl, prop)
`endif

`endif

// ===== rtl/core/deq_pkg.sv =====
package deq_pkg;

   localparam int MAX_RESULTS = 32;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_DUMP       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// ===== rtl/core/deq_if.sv =====
interface deq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic signed [31:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink (input valid, input op, input value, output ready);
endinterface

interface deq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] item_value;
   logic [1:0]         status;
   logic               last_item;
   logic [5:0]         entries_held;

   modport source (output valid, output item_value, output status, output last_item,
                   output entries_held, input ready);
   modport sink (input valid, input item_value, input status, input last_item,
                 input entries_held, output ready);
endinterface

// ===== rtl/core/deq_store.sv =====
module deq_store #(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [31:0]              wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [31:0]              rdata
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/double_ended_queue_unit.sv =====
// push, and empty or full status: result valid the cycle after the transfer
// pop: result loaded from the store's registered read port by the S_READ state once rsp is free
// dump of n entries: first through the read port and S_DUMP, then one per cycle while rsp is free
// with rsp ready, pushes are taken every cycle, pops block requests in S_READ; unused ops give nothing
// synchronous reset clears the state, front pointer, count and result valid
// the entry store is not cleared and needs no clearing pass, only written entries are read
`include "double_ended_queue_unit_defines.svh"

module double_ended_queue_unit #(
   parameter int DEPTH = 32
) (
   input logic        clock,
   input logic        reset,
   deq_req_if.sink    req,
   deq_rsp_if.source  rsp
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DUMP_MAX = (DEPTH < deq_pkg::MAX_RESULTS) ? DEPTH : deq_pkg::MAX_RESULTS;
   localparam int DW = (DUMP_MAX > 1) ? $clog2(DUMP_MAX) : 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [CW-1:0] DUMP_LIMIT = CW'(DUMP_MAX);
   localparam logic [IW:0]   DEPTH_EXT = (IW + 1)'(DEPTH);
   localparam logic [IW-1:0] LAST_INDEX = IW'(DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_DUMP = 3'b100
   } state_type;

   function automatic logic [IW-1:0] wrap_sum(input logic [IW:0] sum);
      logic [IW:0] diff;
      diff = sum - DEPTH_EXT;
      wrap_sum = (sum >= DEPTH_EXT) ? diff[IW-1:0] : sum[IW-1:0];
   endfunction

   state_type   state_ff, state_in;
   logic [IW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [DW-1:0] dump_idx_ff, dump_idx_in;
   logic [DW-1:0] dump_last_ff, dump_last_in;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_item_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_last_ff;
   logic [5:0]         rsp_held_ff;

   logic          st_we, st_re;
   logic [IW-1:0] st_waddr, st_raddr;
   logic [31:0]   st_wdata, st_rdata;

   logic          out_free, accept, full, empty, load, ld_last;
   logic          push_op, pop_op;
   logic [31:0]   ld_item;
   deq_pkg::status_type ld_status;
   logic [IW-1:0] front_dec, front_inc, back_addr, tail_addr, dump_addr;
   logic [IW:0]   front_ext, count_ext;
   logic [CW-1:0] dump_n, dump_n_m1;
   logic [CW+5:0] held_wide;

   deq_store #(.DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .re    (st_re),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign full      = (count_ff == FULL_COUNT);
   assign empty     = (count_ff == '0);
   assign push_op   = (req.op == deq_pkg::OP_PUSH_FRONT) || (req.op == deq_pkg::OP_PUSH_BACK);
   assign pop_op    = (req.op == deq_pkg::OP_POP_FRONT) || (req.op == deq_pkg::OP_POP_BACK);

   assign front_ext = (IW + 1)'(front_ff);
   assign count_ext = (IW + 1)'(count_ff);
   assign front_dec = (front_ff == '0) ? LAST_INDEX : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_INDEX) ? '0 : front_ff + 1'b1;
   assign back_addr = wrap_sum(front_ext + count_ext);
   assign tail_addr = wrap_sum(front_ext + count_ext - 1'b1);
   assign dump_addr = wrap_sum(front_ext + (IW + 1)'(dump_idx_ff) + 1'b1);
   assign dump_n    = (count_ff > DUMP_LIMIT) ? DUMP_LIMIT : count_ff;
   assign dump_n_m1 = dump_n - 1'b1;

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      dump_idx_in  = dump_idx_ff;
      dump_last_in = dump_last_ff;
      st_we        = 1'b0;
      st_waddr     = front_ff;
      st_wdata     = req.value;
      st_re        = 1'b0;
      st_raddr     = front_ff;
      load         = 1'b0;
      ld_item      = '0;
      ld_status    = deq_pkg::ST_OK;
      ld_last      = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (deq_pkg::op_type'(req.op))
                  deq_pkg::OP_PUSH_FRONT: begin
                     load = 1'b1;
                     if (full) begin
                        ld_status = deq_pkg::ST_FULL;
                     end else begin
                        st_we    = 1'b1;
                        st_waddr = front_dec;
                        front_in = front_dec;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  deq_pkg::OP_PUSH_BACK: begin
                     load = 1'b1;
                     if (full) begin
                        ld_status = deq_pkg::ST_FULL;
                     end else begin
                        st_we    = 1'b1;
                        st_waddr = back_addr;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  deq_pkg::OP_POP_FRONT: begin
                     if (empty) begin
                        load      = 1'b1;
                        ld_status = deq_pkg::ST_EMPTY;
                     end else begin
                        st_re    = 1'b1;
                        st_raddr = front_ff;
                        front_in = front_inc;
                        count_in = count_ff - 1'b1;
                        state_in = S_READ;
                     end
                  end
                  deq_pkg::OP_POP_BACK: begin
                     if (empty) begin
                        load      = 1'b1;
                        ld_status = deq_pkg::ST_EMPTY;
                     end else begin
                        st_re    = 1'b1;
                        st_raddr = tail_addr;
                        count_in = count_ff - 1'b1;
                        state_in = S_READ;
                     end
                  end
                  deq_pkg::OP_DUMP: begin
                     if (empty) begin
                        load      = 1'b1;
                        ld_status = deq_pkg::ST_EMPTY;
                     end else begin
                        st_re        = 1'b1;
                        st_raddr     = front_ff;
                        dump_idx_in  = '0;
                        dump_last_in = dump_n_m1[DW-1:0];
                        state_in     = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               load     = 1'b1;
               ld_item  = st_rdata;
               state_in = S_IDLE;
            end
         end
         S_DUMP: begin
            if (out_free) begin
               load    = 1'b1;
               ld_item = st_rdata;
               ld_last = (dump_idx_ff == dump_last_ff);
               if (dump_idx_ff == dump_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  // fetch the next entry while this one is sent
                  st_re       = 1'b1;
                  st_raddr    = dump_addr;
                  dump_idx_in = dump_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign held_wide = {6'b0, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      dump_idx_ff  <= dump_idx_in;
      dump_last_ff <= dump_last_in;
      if (load) begin
         rsp_item_ff   <= ld_item;
         rsp_status_ff <= ld_status;
         rsp_last_ff   <= ld_last;
         rsp_held_ff   <= held_wide[5:0];
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.item_value   = rsp_item_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.last_item    = rsp_last_ff;
   assign rsp.entries_held = rsp_held_ff;

   `DEQ_ASSERT(a_count_bound, (count_ff <= FULL_COUNT))
   `DEQ_ASSERT(a_push_grows, (accept && !full && push_op) |=> (count_ff == $past(count_ff) + 1'b1))
   `DEQ_ASSERT(a_pop_reads, (accept && !empty && pop_op) |=> (state_ff == S_READ))
   `DEQ_ASSERT(a_empty_held, (rsp_valid_ff && rsp_status_ff == deq_pkg::ST_EMPTY) |-> (rsp_held_ff == 6'd0))

endmodule
